@@ rtl/lpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpa_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_MODEM_LORA       = 3'd0;
  localparam logic [2:0] CFG_BANDWIDTH_CODE   = 3'd1;
  localparam logic [2:0] CFG_SPREADING_FACTOR = 3'd2;
  localparam logic [2:0] CFG_CODING_RATE      = 3'd3;
  localparam logic [2:0] CFG_PREAMBLE_SYMBOLS = 3'd4;
  localparam logic [2:0] CFG_CRC_ENABLED      = 3'd5;
  localparam logic [2:0] CFG_HDR_IMPLICIT     = 3'd6;

  // bandwidth codes
  localparam logic [3:0] BW_125K = 4'd7;
  localparam logic [3:0] BW_250K = 4'd8;
  localparam logic [3:0] BW_500K = 4'd9;

  // spreading factor limits
  localparam logic [3:0] SF_MIN = 4'd6;
  localparam logic [3:0] SF_MAX = 4'd12;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned RecipWidth   = 14;
  localparam int unsigned RecipShift   = 16;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FSK    = 2'd1,
    STATUS_BAD_BW = 2'd2
  } status_e;

  typedef struct packed {
    logic        modem_lora;
    logic [3:0]  bandwidth_code;
    logic [3:0]  spreading_factor;
    logic [2:0]  coding_rate;
    logic [15:0] preamble_symbols;
    logic        crc_enabled;
    logic        hdr_implicit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    modem_lora:       1'b1,
    bandwidth_code:   BW_125K,
    spreading_factor: 4'd7,
    coding_rate:      3'd1,
    preamble_symbols: 16'd8,
    crc_enabled:      1'b1,
    hdr_implicit:     1'b0
  };

  // ceil(2^16 / d) for the symbol divisor d = sf - 2*ldro (6..12)
  function automatic logic [RecipWidth-1:0] recip(input logic [3:0] d);
    logic [RecipWidth-1:0] r;
    case (d)
      4'd6:    r = 14'd10923;
      4'd7:    r = 14'd9363;
      4'd8:    r = 14'd8192;
      4'd9:    r = 14'd7282;
      4'd10:   r = 14'd6554;
      4'd11:   r = 14'd5958;
      4'd12:   r = 14'd5462;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lora_packet_airtime.sv @@
`timescale 1ns / 1ps
`default_nettype none

// LoRa time on air. Each request carries a payload length in bytes and
// yields one result: the packet time on air in microseconds, rounded up,
// for the programmed bandwidth, spreading factor, coding rate, preamble
// length, CRC and header mode, with low-data-rate optimization derived
// internally. FSK mode returns 0 with status 1, an unsupported bandwidth
// code returns 0 with status 2. The datapath is a four-stage pipeline
// (setup, reciprocal multiply for the symbol division, symbol count,
// final scale by a shift), so a new request is taken every cycle while
// the output is not stalled. Configuration writes take effect in the
// cycle after the write and must be made while no request is in flight.
module lora_packet_airtime (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [lpa_pkg::CfgDataWidth-1:0] cfg_data_i,
  // request stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] payload_length
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] air_time_us
  output logic [1:0]  m_axis_tuser    // [1:0] result_status
);

  lpa_pkg::cfg_t cfg;

  lpa_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // stage enables, a stage moves when it is empty or its successor moves
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo          = !vo_q || m_axis_tready;
  assign rdy3          = !v3_q || rdyo;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  // setup: clamp sf, derive ldro, divisor, numerator, shift and status
  logic [3:0]  sf;
  logic        ldro;
  logic [3:0]  sym_div;
  logic [11:0] num_pos;
  logic [11:0] num_neg;
  logic [11:0] num_diff;
  logic [9:0]  n4;
  logic [9:0]  m_d;
  logic [3:0]  sh_d;
  lpa_pkg::status_e st_d;

  always_comb begin
    if (cfg.spreading_factor < lpa_pkg::SF_MIN) begin
      sf = lpa_pkg::SF_MIN;
    end else if (cfg.spreading_factor > lpa_pkg::SF_MAX) begin
      sf = lpa_pkg::SF_MAX;
    end else begin
      sf = cfg.spreading_factor;
    end

    ldro = ((cfg.bandwidth_code == lpa_pkg::BW_125K) && (sf >= 4'd11)) ||
           ((cfg.bandwidth_code == lpa_pkg::BW_250K) && (sf == 4'd12));
    sym_div = sf - {2'b00, ldro, 1'b0};

    // 8*pl + 28 + 16*crc against 4*sf + 20*ih
    num_pos  = {1'b0, s_axis_tdata, 3'b000} + 12'd28 + {7'd0, cfg.crc_enabled, 4'd0};
    num_neg  = {6'd0, sf, 2'b00} + (cfg.hdr_implicit ? 12'd20 : 12'd0);
    num_diff = num_pos - num_neg;
    // ceil(diff / 4), then ceil(./d) is floor((n4 + d - 1) / d)
    n4 = 10'((num_diff + 12'd3) >> 2);
    m_d = (num_pos > num_neg) ? (n4 + {6'd0, sym_div} - 10'd1) : '0;

    // 2^sf * 1e6 / (4 * bw) is a power of two for all supported bandwidths
    if (cfg.bandwidth_code == lpa_pkg::BW_125K) begin
      sh_d = sf + 4'd1;
    end else if (cfg.bandwidth_code == lpa_pkg::BW_250K) begin
      sh_d = sf;
    end else begin
      sh_d = sf - 4'd1;
    end

    if (!cfg.modem_lora) begin
      st_d = lpa_pkg::STATUS_FSK;
    end else if ((cfg.bandwidth_code != lpa_pkg::BW_125K) &&
                 (cfg.bandwidth_code != lpa_pkg::BW_250K) &&
                 (cfg.bandwidth_code != lpa_pkg::BW_500K)) begin
      st_d = lpa_pkg::STATUS_BAD_BW;
    end else begin
      st_d = lpa_pkg::STATUS_OK;
    end
  end

  // stage 1 registers
  logic [9:0]                     m1_q;
  logic [lpa_pkg::RecipWidth-1:0] r1_q;
  logic [3:0]                     cr1_q, cr2_q;
  logic [18:0]                    base1_q, base2_q;
  logic [3:0]                     sh1_q, sh2_q, sh3_q;
  lpa_pkg::status_e               st1_q, st2_q, st3_q, sto_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      m1_q    <= m_d;
      r1_q    <= lpa_pkg::recip(sym_div);
      cr1_q   <= {1'b0, cfg.coding_rate} + 4'd4;
      // 4*preamble + 17 quarters, plus the fixed 8 payload symbols
      base1_q <= {1'b0, cfg.preamble_symbols, 2'b00} + 19'd49;
      sh1_q   <= sh_d;
      st1_q   <= st_d;
    end
  end

  // stage 2: reciprocal multiply gives the payload block count
  logic [23:0] prod;
  logic [7:0]  q2_q;

  assign prod = {14'd0, m1_q} * {10'd0, r1_q};

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      q2_q    <= prod[23:lpa_pkg::RecipShift];
      cr2_q   <= cr1_q;
      base2_q <= base1_q;
      sh2_q   <= sh1_q;
      st2_q   <= st1_q;
    end
  end

  // stage 3: total length in quarter symbols
  logic [11:0] sym3;
  logic [19:0] quarters3_q;

  assign sym3 = {4'd0, q2_q} * {8'd0, cr2_q};

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      quarters3_q <= {1'b0, base2_q} + {6'd0, sym3, 2'b00};
      sh3_q       <= sh2_q;
      st3_q       <= st2_q;
    end
  end

  // output stage: scale to microseconds
  logic [31:0] scaled;
  logic [31:0] out_q;

  assign scaled = {12'd0, quarters3_q} << sh3_q;

  always_ff @(posedge clk_i) begin
    if (rdyo) begin
      out_q <= (st3_q == lpa_pkg::STATUS_OK) ? scaled : '0;
      sto_q <= st3_q;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = sto_q;

endmodule

`default_nettype wire

@@ rtl/lpa_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpa_cfg_regs (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                wr_en_i,
  input  wire  [2:0]                         wr_index_i,
  input  wire  [lpa_pkg::CfgDataWidth-1:0]   wr_data_i,
  output lpa_pkg::cfg_t                      cfg_o
);

  lpa_pkg::cfg_t cfg_d, cfg_q;

  // register decode, writes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        lpa_pkg::CFG_MODEM_LORA:       cfg_d.modem_lora       = wr_data_i[0];
        lpa_pkg::CFG_BANDWIDTH_CODE:   cfg_d.bandwidth_code   = wr_data_i[3:0];
        lpa_pkg::CFG_SPREADING_FACTOR: cfg_d.spreading_factor = wr_data_i[3:0];
        lpa_pkg::CFG_CODING_RATE:      cfg_d.coding_rate      = wr_data_i[2:0];
        lpa_pkg::CFG_PREAMBLE_SYMBOLS: cfg_d.preamble_symbols = wr_data_i[15:0];
        lpa_pkg::CFG_CRC_ENABLED:      cfg_d.crc_enabled      = wr_data_i[0];
        lpa_pkg::CFG_HDR_IMPLICIT:     cfg_d.hdr_implicit     = wr_data_i[0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lpa_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/lpa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpa_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        cfg_ready_o,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))
    else $error("result changed while stalled");

  // back pressure on requests only comes from a stalled full pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request stalled without output back pressure");

  // results that were not computed read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != lpa_pkg::STATUS_OK) |-> m_axis_tdata == '0)
    else $error("nonzero airtime on error status");

  // a computed airtime always covers at least the preamble tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == lpa_pkg::STATUS_OK) |-> m_axis_tdata != '0)
    else $error("zero airtime with ok status");

  // register writes are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind lora_packet_airtime lpa_checker u_lpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_ready_o   (cfg_ready_o),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
